### hw/rtl/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// Used by gha_ctrl, gha_datapath and generational_handle_allocator_unit.
// No dependencies.
package gha_pkg;

    localparam int SLOTS  = 256;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int GEN_W  = 16;
    localparam int PAY_W  = 32;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input beat and read the tables
        logic commit;    // update the tables and load the result register
    } gha_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall; // result register holds a beat that is not taken
    } gha_stat_t;

    // A free stack entry keeps the slot and the generation it was left with.
    typedef struct packed {
        logic [IDX_W-1:0] slot;
        logic [GEN_W-1:0] gen;
    } gha_stack_entry_t;

endpackage

### hw/rtl/generational_handle_allocator_unit.sv
// Generational handle allocator, top level. Depends on gha_pkg, gha_ctrl, gha_datapath.
// A beat's table reads are registered when it is accepted; its result is loaded into
// the output register at commit, which waits while an earlier result is not taken.
// A new beat is not accepted until the previous one is committed: the tables are read
// at accept and written at commit, and a result that is held back delays the commit.
// Reset (aresetn, synchronous, active low) clears counters, occupancy and handshakes.
module generational_handle_allocator_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [gha_pkg::KIND_W-1:0]      s_kind,
    input  logic [gha_pkg::IDX_W-1:0]       s_slot_index,
    input  logic [gha_pkg::GEN_W-1:0]       s_handle_generation,
    input  logic [gha_pkg::PAY_W-1:0]       s_payload_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gha_pkg::STAT_W-1:0]      m_status,
    output logic [gha_pkg::IDX_W-1:0]       m_handle_index,
    output logic [gha_pkg::GEN_W-1:0]       m_handle_gen_out,
    output logic [gha_pkg::PAY_W-1:0]       m_payload_out
);

    // The controller alternates between taking a beat (tables are read at that
    // edge) and executing it (tables are written and the result register is
    // loaded). Execution waits only while the result register still holds a
    // beat the downstream side has not taken, so a new input beat can be taken
    // while an old result waits.
    gha_pkg::gha_cmd_t  cmd;
    gha_pkg::gha_stat_t stat;

    gha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the generation and payload tables, the occupancy
    // flags, the LIFO free stack (each entry remembers its generation, so a
    // reuse needs only one stack read) and the high-water mark.
    gha_datapath u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .s_kind              (s_kind),
        .s_slot_index        (s_slot_index),
        .s_handle_generation (s_handle_generation),
        .s_payload_in        (s_payload_in),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_handle_index      (m_handle_index),
        .m_handle_gen_out    (m_handle_gen_out),
        .m_payload_out       (m_payload_out)
    );

endmodule

### hw/rtl/gha_ctrl.sv
// Controller state machine for the generational handle allocator.
// Depends on gha_pkg for the command and status structs.
module gha_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gha_pkg::gha_stat_t stat,
    output gha_pkg::gha_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                // Wait only while the previous result still sits unread.
                if (!stat.out_stall) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/gha_datapath.sv
// Datapath of the generational handle allocator: slot tables, free stack,
// counters and the result register. Depends on gha_pkg.
module gha_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gha_pkg::gha_cmd_t               cmd,
    output gha_pkg::gha_stat_t              stat,
    input  logic [gha_pkg::KIND_W-1:0]      s_kind,
    input  logic [gha_pkg::IDX_W-1:0]       s_slot_index,
    input  logic [gha_pkg::GEN_W-1:0]       s_handle_generation,
    input  logic [gha_pkg::PAY_W-1:0]       s_payload_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gha_pkg::STAT_W-1:0]      m_status,
    output logic [gha_pkg::IDX_W-1:0]       m_handle_index,
    output logic [gha_pkg::GEN_W-1:0]       m_handle_gen_out,
    output logic [gha_pkg::PAY_W-1:0]       m_payload_out
);

    // Tables and free stack.
    logic [gha_pkg::GEN_W-1:0]   gen_mem [gha_pkg::SLOTS];
    logic [gha_pkg::PAY_W-1:0]   pay_mem [gha_pkg::SLOTS];
    gha_pkg::gha_stack_entry_t    stk_mem [gha_pkg::SLOTS];
    logic [gha_pkg::SLOTS-1:0]   occ_reg;
    logic [gha_pkg::SLOTS-1:0]   occ_next;

    logic [gha_pkg::CNT_W-1:0]   fc_reg;
    logic [gha_pkg::CNT_W-1:0]   fc_next;
    logic [gha_pkg::CNT_W-1:0]   hw_reg;
    logic [gha_pkg::CNT_W-1:0]   hw_next;

    // Captured beat and registered table reads.
    logic [gha_pkg::KIND_W-1:0]  kind_reg;
    logic [gha_pkg::IDX_W-1:0]   idx_reg;
    logic [gha_pkg::GEN_W-1:0]   hgen_reg;
    logic [gha_pkg::PAY_W-1:0]   pin_reg;
    logic [gha_pkg::GEN_W-1:0]   gen_rd_reg;
    logic [gha_pkg::PAY_W-1:0]   pay_rd_reg;
    logic                        occ_rd_reg;
    gha_pkg::gha_stack_entry_t    stk_rd_reg;

    // Result register.
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [gha_pkg::STAT_W-1:0]  m_status_reg;
    logic [gha_pkg::IDX_W-1:0]   m_index_reg;
    logic [gha_pkg::GEN_W-1:0]   m_gen_reg;
    logic [gha_pkg::PAY_W-1:0]   m_pay_reg;

    // Execute-step decisions.
    logic [gha_pkg::STAT_W-1:0]  res_status;
    logic [gha_pkg::IDX_W-1:0]   res_index;
    logic [gha_pkg::GEN_W-1:0]   res_gen;
    logic [gha_pkg::PAY_W-1:0]   res_pay;
    logic [gha_pkg::IDX_W-1:0]   wr_slot;
    logic [gha_pkg::GEN_W-1:0]   gen_wdata;
    logic                        gen_we;
    logic                        pay_we;
    logic                        occ_set;
    logic                        occ_clr;
    logic                        stk_we;
    gha_pkg::gha_stack_entry_t    stk_wdata;
    logic [gha_pkg::IDX_W-1:0]   stk_top;
    logic                        in_range;
    logic                        gen_match;

    assign stk_top   = gha_pkg::IDX_W'(fc_reg - gha_pkg::CNT_W'(1));
    assign in_range  = {1'b0, idx_reg} < hw_reg;
    assign gen_match = (gen_rd_reg == hgen_reg) && occ_rd_reg;

    // Read side: all table reads happen at the accept edge.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= s_kind;
            idx_reg    <= s_slot_index;
            hgen_reg   <= s_handle_generation;
            pin_reg    <= s_payload_in;
            gen_rd_reg <= gen_mem[s_slot_index];
            pay_rd_reg <= pay_mem[s_slot_index];
            occ_rd_reg <= occ_reg[s_slot_index];
            stk_rd_reg <= stk_mem[stk_top];
        end
    end

    always_comb begin
        res_status = gha_pkg::ST_MISS;
        res_index  = idx_reg;
        res_gen    = hgen_reg;
        res_pay    = '0;
        wr_slot    = idx_reg;
        gen_wdata  = gen_rd_reg + gha_pkg::GEN_W'(1);
        gen_we     = 1'b0;
        pay_we     = 1'b0;
        occ_set    = 1'b0;
        occ_clr    = 1'b0;
        stk_we     = 1'b0;
        stk_wdata  = '{slot: idx_reg, gen: gen_rd_reg + gha_pkg::GEN_W'(1)};
        fc_next    = fc_reg;
        hw_next    = hw_reg;
        unique case (kind_reg)
            gha_pkg::KIND_ALLOC: begin
                if (fc_reg != '0) begin
                    wr_slot    = stk_rd_reg.slot;
                    gen_wdata  = stk_rd_reg.gen + gha_pkg::GEN_W'(1);
                    fc_next    = fc_reg - gha_pkg::CNT_W'(1);
                    res_status = gha_pkg::ST_OK;
                end else if (hw_reg != gha_pkg::SLOTS_CNT) begin
                    wr_slot    = gha_pkg::IDX_W'(hw_reg);
                    gen_wdata  = '0;
                    hw_next    = hw_reg + gha_pkg::CNT_W'(1);
                    res_status = gha_pkg::ST_OK;
                end else begin
                    res_status = gha_pkg::ST_FULL;
                end
                if (res_status == gha_pkg::ST_OK) begin
                    gen_we    = 1'b1;
                    pay_we    = 1'b1;
                    occ_set   = 1'b1;
                    res_index = wr_slot;
                    res_gen   = gen_wdata;
                end
            end
            gha_pkg::KIND_FREE: begin
                if (!in_range) begin
                    res_status = gha_pkg::ST_RANGE;
                end else if (gen_match) begin
                    res_status = gha_pkg::ST_OK;
                    gen_we     = 1'b1;
                    occ_clr    = 1'b1;
                    if (fc_reg != gha_pkg::SLOTS_CNT) begin
                        stk_we  = 1'b1;
                        fc_next = fc_reg + gha_pkg::CNT_W'(1);
                    end
                end
            end
            gha_pkg::KIND_LOOKUP: begin
                if (in_range && gen_match) begin
                    res_status = gha_pkg::ST_OK;
                    res_pay    = pay_rd_reg;
                end
            end
            default: begin
                res_status = gha_pkg::ST_MISS;
            end
        endcase
    end

    // Write side: tables change only at the commit edge.
    always_ff @(posedge aclk) begin
        if (cmd.commit && gen_we) begin
            gen_mem[wr_slot] <= gen_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && pay_we) begin
            pay_mem[wr_slot] <= pin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && stk_we) begin
            stk_mem[gha_pkg::IDX_W'(fc_reg)] <= stk_wdata;
        end
    end

    always_comb begin
        occ_next = occ_reg;
        if (cmd.commit && occ_set) begin
            occ_next[wr_slot] = 1'b1;
        end
        if (cmd.commit && occ_clr) begin
            occ_next[wr_slot] = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            fc_reg      <= '0;
            hw_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            if (cmd.commit) begin
                fc_reg <= fc_next;
                hw_reg <= hw_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status_reg <= res_status;
            m_index_reg  <= res_index;
            m_gen_reg    <= res_gen;
            m_pay_reg    <= res_pay;
        end
    end

    assign stat.out_stall  = m_valid_reg && !m_ready;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_handle_index   = m_index_reg;
    assign m_handle_gen_out = m_gen_reg;
    assign m_payload_out    = m_pay_reg;

    // Every slot on the free stack was once handed out below the mark.
    a_fc_le_hw: assert property (@(posedge aclk) disable iff (!aresetn)
        fc_reg <= hw_reg)
        else $error("free count exceeds high-water mark");

    a_hw_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hw_reg <= gha_pkg::SLOTS_CNT)
        else $error("high-water mark beyond table size");

    // A successful alloc leaves its slot occupied.
    a_alloc_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && kind_reg == gha_pkg::KIND_ALLOC && res_status == gha_pkg::ST_OK)
        |=> occ_reg[$past(wr_slot)])
        else $error("allocated slot not marked occupied");

    // A commit never overwrites a result that is still waiting.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_valid_reg && !m_ready))
        else $error("result register overwritten while stalled");

endmodule
